>>> src/twdbf_pkg.sv
`default_nettype none

package twdbf_pkg;

  localparam int unsigned DataPeriods = 8;
  localparam int unsigned PeriodW = 4;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_IDLE  = 2'd2
  } op_t;

  typedef struct packed {
    logic       func;
    logic [1:0] op_kind;
    logic       start_flag;
    logic       stop_level;
    logic [7:0] tx_byte;
    logic [7:0] idle_count;
    logic       data_in;
  } in_item_t;

  typedef struct packed {
    logic       clock_pulse;
    logic       data_level;
    logic       data_drive;
    logic [7:0] rx_byte;
    logic       last_period;
    logic       rejected;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/twdbf_in_if.sv
`default_nettype none

interface twdbf_in_if;
  logic                 valid;
  logic                 ready;
  twdbf_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/twdbf_out_if.sv
`default_nettype none

interface twdbf_out_if;
  logic                 valid;
  logic                 ready;
  twdbf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/two_wire_debug_byte_framer.sv
// Master-side byte framer for a two-wire clock/data debug link. A load
// transaction (func 0) starts a byte write, a byte read or a run of idle
// clocks; each tick transaction (func 1) then yields one clock period with
// the data level, the drive enable and the bits read so far. A load while
// an operation runs answers with a rejected result and changes nothing.
// Every transaction is registered at the input, handled by the shift and
// count logic, and its result (if any) lands in an output register, so one
// transaction is taken per clock while the output is drained; a result is
// offered from the output register once its transaction has passed the
// input register, and it waits there while the output is stalled.
`default_nettype none

module two_wire_debug_byte_framer (
  input  wire              clk,
  input  wire              rst,
  twdbf_in_if.sink         in_ch,
  twdbf_out_if.source      out_ch
);

  logic                           in_full;
  twdbf_pkg::in_item_t            in_q;
  logic                           advance;

  logic                           busy, busy_next;
  twdbf_pkg::op_t                 cmd_kind, cmd_kind_next;
  logic [twdbf_pkg::PeriodW-1:0]  period_index, period_index_next;
  logic [7:0]                     shift_reg, shift_reg_next;
  logic [7:0]                     idle_left, idle_left_next;
  logic                           start_pending, start_pending_next;
  logic                           stop_value, stop_value_next;
  logic                           line_level, line_level_next;

  logic                           res_valid;
  twdbf_pkg::out_item_t           res;
  logic                           out_valid;
  twdbf_pkg::out_item_t           out_q;

  logic                           released;
  logic                           in_data_periods;
  logic [7:0]                     rx_now;
  logic [7:0]                     idle_dec;

  assign advance      = in_full && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !in_full || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  assign in_data_periods = (period_index < twdbf_pkg::PeriodW'(twdbf_pkg::DataPeriods));
  assign released = (cmd_kind == twdbf_pkg::OP_READ) && !start_pending && in_data_periods;
  assign rx_now   = (cmd_kind == twdbf_pkg::OP_READ) ? shift_reg : 8'h00;
  assign idle_dec = idle_left - 8'd1;

  always_comb begin
    busy_next          = busy;
    cmd_kind_next      = cmd_kind;
    period_index_next  = period_index;
    shift_reg_next     = shift_reg;
    idle_left_next     = idle_left;
    start_pending_next = start_pending;
    stop_value_next    = stop_value;
    line_level_next    = line_level;
    res_valid          = 1'b0;
    res                = '0;
    if (in_q.func == twdbf_pkg::FUNC_LOAD) begin
      if (busy) begin
        res_valid      = 1'b1;
        res.rejected   = 1'b1;
        res.data_level = released ? 1'b0 : line_level;
        res.data_drive = !released;
      end else begin
        case (in_q.op_kind)
          twdbf_pkg::OP_IDLE: begin
            cmd_kind_next   = twdbf_pkg::OP_IDLE;
            idle_left_next  = in_q.idle_count;
            line_level_next = 1'b1;
            busy_next       = |in_q.idle_count;
          end
          twdbf_pkg::OP_WRITE, twdbf_pkg::OP_READ: begin
            cmd_kind_next      = twdbf_pkg::op_t'(in_q.op_kind);
            start_pending_next = in_q.start_flag;
            stop_value_next    = in_q.stop_level;
            shift_reg_next     = (in_q.op_kind == twdbf_pkg::OP_WRITE) ? in_q.tx_byte : 8'h00;
            period_index_next  = '0;
            busy_next          = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (busy) begin
      res_valid       = 1'b1;
      res.clock_pulse = 1'b1;
      res.data_drive  = 1'b1;
      if (cmd_kind == twdbf_pkg::OP_IDLE) begin
        line_level_next = 1'b1;
        idle_left_next  = idle_dec;
        busy_next       = |idle_dec;
        res.data_level  = 1'b1;
        res.last_period = ~|idle_dec;
      end else if (start_pending) begin
        start_pending_next = 1'b0;
        line_level_next    = 1'b0;
        res.rx_byte        = rx_now;
      end else if (in_data_periods) begin
        period_index_next = period_index + twdbf_pkg::PeriodW'(1);
        if (cmd_kind == twdbf_pkg::OP_READ) begin
          shift_reg_next = {in_q.data_in, shift_reg[7:1]};
          res.data_drive = 1'b0;
          res.rx_byte    = {in_q.data_in, shift_reg[7:1]};
        end else begin
          shift_reg_next  = {1'b0, shift_reg[7:1]};
          line_level_next = shift_reg[0];
          res.data_level  = shift_reg[0];
        end
      end else begin
        line_level_next = stop_value;
        busy_next       = 1'b0;
        res.data_level  = stop_value;
        res.rx_byte     = rx_now;
        res.last_period = 1'b1;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= in_ch.data;
    end
  end

  // framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      cmd_kind      <= twdbf_pkg::OP_WRITE;
      period_index  <= '0;
      shift_reg     <= 8'h00;
      idle_left     <= 8'h00;
      start_pending <= 1'b0;
      stop_value    <= 1'b0;
      line_level    <= 1'b0;
    end else if (advance) begin
      busy          <= busy_next;
      cmd_kind      <= cmd_kind_next;
      period_index  <= period_index_next;
      shift_reg     <= shift_reg_next;
      idle_left     <= idle_left_next;
      start_pending <= start_pending_next;
      stop_value    <= stop_value_next;
      line_level    <= line_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ClkPeriod = 12;
  localparam int ItemTarget = 1850;
  localparam int CycleLimit = 400000;
  localparam int HoldAt = 500;
  localparam int HoldCycles = 300;
  localparam int PauseAt = 900;
  localparam int DrainCycles = 10;
  localparam int MaxReports = 10;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam twdbf_pkg::out_item_t NoResult = '0;

  typedef struct packed {
    twdbf_pkg::in_item_t  item;
    logic                 typed;
    twdbf_pkg::out_item_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  twdbf_in_if in_ch ();
  twdbf_out_if out_ch ();

  two_wire_debug_byte_framer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // link framer state mirrored by the predictor
  logic           link_busy = 1'b0;
  twdbf_pkg::op_t run_kind = twdbf_pkg::OP_WRITE;
  logic [3:0]     bits_done = '0;
  logic [7:0]     shifter = '0;
  logic [7:0]     idle_left = '0;
  logic           start_due = 1'b0;
  logic           stop_bit = 1'b0;
  logic           line_lvl = 1'b0;

  twdbf_pkg::out_item_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int tx_calm_left = 0;
  int rx_calm_left = 0;
  row_t directed [26];

  function automatic logic frame_step(input twdbf_pkg::in_item_t it,
                                      output twdbf_pkg::out_item_t res);
    logic released;
    res = '0;
    if (it.func == twdbf_pkg::FUNC_LOAD) begin
      if (link_busy) begin
        released = (run_kind == twdbf_pkg::OP_READ) && !start_due &&
                   (bits_done < twdbf_pkg::DataPeriods);
        res.data_level = released ? 1'b0 : line_lvl;
        res.data_drive = !released;
        res.rejected = 1'b1;
        return 1'b1;
      end
      case (it.op_kind)
        twdbf_pkg::OP_IDLE: begin
          run_kind = twdbf_pkg::OP_IDLE;
          idle_left = it.idle_count;
          line_lvl = 1'b1;
          link_busy = (it.idle_count != 0);
        end
        twdbf_pkg::OP_WRITE, twdbf_pkg::OP_READ: begin
          run_kind = twdbf_pkg::op_t'(it.op_kind);
          start_due = it.start_flag;
          stop_bit = it.stop_level;
          shifter = (it.op_kind == twdbf_pkg::OP_WRITE) ? it.tx_byte : 8'h00;
          bits_done = '0;
          link_busy = 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    end
    if (!link_busy) return 1'b0;
    res.clock_pulse = 1'b1;
    res.data_drive = 1'b1;
    if (run_kind == twdbf_pkg::OP_IDLE) begin
      line_lvl = 1'b1;
      idle_left = idle_left - 8'd1;
      link_busy = (idle_left != 0);
      res.data_level = 1'b1;
      res.last_period = !link_busy;
      return 1'b1;
    end
    res.rx_byte = (run_kind == twdbf_pkg::OP_READ) ? shifter : 8'h00;
    if (start_due) begin
      start_due = 1'b0;
      line_lvl = 1'b0;
      return 1'b1;
    end
    if (bits_done < twdbf_pkg::DataPeriods) begin
      bits_done = bits_done + 4'd1;
      if (run_kind == twdbf_pkg::OP_READ) begin
        shifter = {it.data_in, shifter[7:1]};
        res.data_drive = 1'b0;
        res.rx_byte = shifter;
      end else begin
        line_lvl = shifter[0];
        res.data_level = shifter[0];
        shifter = {1'b0, shifter[7:1]};
      end
      return 1'b1;
    end
    line_lvl = stop_bit;
    link_busy = 1'b0;
    res.data_level = stop_bit;
    res.last_period = 1'b1;
    return 1'b1;
  endfunction

  function automatic twdbf_pkg::in_item_t cmd(logic [1:0] op, logic st, logic sp,
                                              logic [7:0] tx, logic [7:0] cnt);
    twdbf_pkg::in_item_t it;
    it = '0;
    it.func = twdbf_pkg::FUNC_LOAD;
    it.op_kind = op;
    it.start_flag = st;
    it.stop_level = sp;
    it.tx_byte = tx;
    it.idle_count = cnt;
    return it;
  endfunction

  function automatic twdbf_pkg::in_item_t tick(logic din);
    twdbf_pkg::in_item_t it;
    it = '0;
    it.func = twdbf_pkg::FUNC_TICK;
    it.data_in = din;
    return it;
  endfunction

  function automatic twdbf_pkg::out_item_t outcome(logic cp, logic lvl, logic drv,
                                                   logic [7:0] rx, logic last, logic rej);
    return '{cp, lvl, drv, rx, last, rej};
  endfunction

  function automatic twdbf_pkg::in_item_t random_item(logic fn);
    logic [31:0] r;
    twdbf_pkg::in_item_t it;
    r = $urandom;
    it = r[$bits(twdbf_pkg::in_item_t)-1:0];
    it.func = fn;
    return it;
  endfunction

  task automatic send(input twdbf_pkg::in_item_t it, input logic typed,
                      input twdbf_pkg::out_item_t want);
    int gap;
    twdbf_pkg::out_item_t res;
    if (tx_calm_left > 0) begin
      gap = 0;
      tx_calm_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      gap = 0;
      tx_calm_left = 60;
    end else begin
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (frame_step(it, res) || typed) pending_results.push_back(typed ? want : res);
  endtask

  // stimulus
  initial begin
    int issued;
    int periods;
    int pick;
    logic paused;
    twdbf_pkg::in_item_t it;
    issued = 0;
    paused = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    directed = '{
      '{tick(1'b0), 1'b0, NoResult},
      '{cmd(twdbf_pkg::OP_IDLE, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0, NoResult},
      '{cmd(OpUnused, 1'b1, 1'b1, 8'hFF, 8'hFF), 1'b0, NoResult},
      '{cmd(twdbf_pkg::OP_READ, 1'b0, 1'b1, 8'hFF, 8'hFF), 1'b0, NoResult},
      '{cmd(twdbf_pkg::OP_WRITE, 1'b1, 1'b1, 8'h00, 8'h00), 1'b1,
        outcome(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1)},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b1), 1'b0, NoResult},
      '{tick(1'b0), 1'b1, outcome(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0)},
      '{cmd(twdbf_pkg::OP_WRITE, 1'b1, 1'b0, 8'hFF, 8'h00), 1'b0, NoResult},
      '{cmd(twdbf_pkg::OP_IDLE, 1'b0, 1'b0, 8'h00, 8'hFF), 1'b1,
        outcome(1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1)},
      '{tick(1'b0), 1'b1, outcome(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0)},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b0), 1'b0, NoResult},
      '{tick(1'b1), 1'b1, outcome(1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0)}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].want);

    while (issued < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // stray tick or unused opcode while the link is quiet
        it = random_item(pick < 3 ? twdbf_pkg::FUNC_TICK : twdbf_pkg::FUNC_LOAD);
        if (pick >= 3) it.op_kind = OpUnused;
        send(it, 1'b0, NoResult);
      end else begin
        it = random_item(twdbf_pkg::FUNC_LOAD);
        pick = $urandom_range(0, 9);
        it.op_kind = (pick < 4) ? twdbf_pkg::OP_WRITE :
                     (pick < 8) ? twdbf_pkg::OP_READ : twdbf_pkg::OP_IDLE;
        if (it.op_kind == twdbf_pkg::OP_IDLE) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) it.idle_count = 8'h00;
          else if (pick == 1) it.idle_count = 8'hFF;
          else if (pick == 2) it.idle_count = 8'($urandom_range(0, 255));
          else it.idle_count = 8'($urandom_range(1, 6));
          periods = int'(it.idle_count);
        end else begin
          periods = 9 + int'(it.start_flag);
        end
        send(it, 1'b0, NoResult);
        issued++;
        for (int k = 0; k < periods; k++) begin
          // a load in the middle of a running operation
          if ($urandom_range(0, 15) == 0) begin
            send(random_item(twdbf_pkg::FUNC_LOAD), 1'b0, NoResult);
            issued++;
          end
          send(random_item(twdbf_pkg::FUNC_TICK), 1'b0, NoResult);
          issued++;
        end
        if (!paused && issued >= PauseAt) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          wait (pending_results.size() == 0);
          @(posedge clk);
        end
      end
    end
    in_ch.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result sink with random back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (results_seen == HoldAt) begin
        gap = HoldCycles;
      end else if (rx_calm_left > 0) begin
        gap = 0;
        rx_calm_left--;
      end else if ($urandom_range(0, 99) == 0) begin
        gap = 0;
        rx_calm_left = 50;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    twdbf_pkg::out_item_t oldest;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < MaxReports) $display("unexpected transaction: %p", out_ch.data);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.data !== oldest) begin
          if (mismatches < MaxReports) begin
            $display("mismatch exp/got: clk %0b/%0b lvl %0b/%0b drv %0b/%0b rx %02h/%02h",
                     oldest.clock_pulse, out_ch.data.clock_pulse, oldest.data_level,
                     out_ch.data.data_level, oldest.data_drive, out_ch.data.data_drive,
                     oldest.rx_byte, out_ch.data.rx_byte);
            $display("  last %0b/%0b rej %0b/%0b", oldest.last_period,
                     out_ch.data.last_period, oldest.rejected, out_ch.data.rejected);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

>>> files.f
src/twdbf_pkg.sv
src/twdbf_in_if.sv
src/twdbf_out_if.sv
src/two_wire_debug_byte_framer.sv
verif/testbench.sv
